// ===== hw/rtl/fnas_pkg.sv =====
// Shared constants, the result control struct and configuration helpers
// for the four-neighbor average stencil. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fnas_pkg;

    localparam int DEF_MAX_COLS       = 8192;
    localparam int DEF_PIXEL_BITS     = 32;

    localparam int FRAME_WIDTH_W      = 14;
    localparam int FRAME_HEIGHT_W     = 16;
    localparam int ROW_W              = 16;
    localparam int OUT_COL_W          = 13;
    localparam int WLAST_W            = 17;

    localparam int CFG_INDEX_W        = 2;
    localparam int CFG_DATA_W         = 16;

    localparam int FRAME_WIDTH_RESET  = 5120;
    localparam int FRAME_HEIGHT_RESET = 8192;

    localparam int RESULTS_MAX        = 3;
    localparam int SLOT_W             = 2;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = CFG_INDEX_W'(1);

    // Results caused by one input pixel, packed in emission order
    typedef struct packed {
        logic [SLOT_W-1:0]                     count;
        logic [RESULTS_MAX-1:0]                eof;
        logic [RESULTS_MAX-1:0][ROW_W-1:0]     row;
        logic [RESULTS_MAX-1:0][OUT_COL_W-1:0] col;
    } res_ctrl_t;

    // Index of the last column in use: zero acts as one, clamp to the store depth
    function automatic logic [WLAST_W-1:0] width_last(
        input logic [FRAME_WIDTH_W-1:0] fw,
        input logic [WLAST_W-1:0]       max_cols
    );
        logic [WLAST_W-1:0] w;
        w = (fw == '0) ? WLAST_W'(1) : WLAST_W'(fw);
        if (w > max_cols) begin
            w = max_cols;
        end
        return w - WLAST_W'(1);
    endfunction

    // Index of the last row in use: zero acts as one
    function automatic logic [ROW_W-1:0] height_last(
        input logic [FRAME_HEIGHT_W-1:0] fh
    );
        return (fh == '0) ? '0 : ROW_W'(fh - FRAME_HEIGHT_W'(1));
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fnas_line_mem.sv =====
// Line store: one synchronous memory holding the two previous rows per column,
// one write and one registered read per cycle. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fnas_line_mem #(
    parameter int DEPTH  = 8192,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 13
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read-first: a read of the entry being written returns the old contents
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fnas_kernel.sv =====
// Raster counters, line store access with forwarding, and the stencil sums.
// Depends on fnas_pkg; drives the fnas_line_mem ports.
`timescale 1ns / 1ps
`default_nettype none

module fnas_kernel #(
    parameter int MAX_COLS   = fnas_pkg::DEF_MAX_COLS,
    parameter int PIXEL_BITS = fnas_pkg::DEF_PIXEL_BITS,
    parameter int COL_W      = 13
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    cfg_wr_en,
    input  wire logic [fnas_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [fnas_pkg::CFG_DATA_W-1:0]         cfg_wr_data,
    input  wire logic                                    in_valid,
    input  wire logic                                    in_ready,
    input  wire logic signed [PIXEL_BITS-1:0]            pixel_in,
    output      logic                                    mem_wr_en,
    output      logic [COL_W-1:0]                        mem_wr_addr,
    output      logic [2*PIXEL_BITS-1:0]                 mem_wr_data,
    output      logic                                    mem_rd_en,
    output      logic [COL_W-1:0]                        mem_rd_addr,
    input  wire logic [2*PIXEL_BITS-1:0]                 mem_rd_data,
    output      logic                                    stage_busy,
    output      logic                                    res_valid,
    output      fnas_pkg::res_ctrl_t                     res_ctrl,
    output      logic [fnas_pkg::RESULTS_MAX-1:0][PIXEL_BITS-1:0] res_pix
);

    localparam int ENTRY_W = 2 * PIXEL_BITS;
    localparam int SUM_W   = PIXEL_BITS + 2;
    localparam int ROW_W   = fnas_pkg::ROW_W;

    logic [COL_W-1:0]              width_last_reg;
    logic [ROW_W-1:0]              height_last_reg;
    logic [ROW_W-1:0]              row_reg, row_next;
    logic [COL_W-1:0]              col_reg, col_next;
    logic signed [PIXEL_BITS-1:0]  prev_reg, prev_next;
    logic signed [PIXEL_BITS-1:0]  prev2_reg, prev2_next;
    logic signed [PIXEL_BITS-1:0]  bprev_reg, bprev_next;
    logic                          fwd_valid_reg;
    logic [ENTRY_W-1:0]            fwd_data_reg;

    logic                          accept;
    logic                          cfg_restart;
    logic                          last_col;
    logic                          last_row;
    logic [ENTRY_W-1:0]            entry;
    logic signed [PIXEL_BITS-1:0]  older;
    logic signed [PIXEL_BITS-1:0]  newer;
    logic [COL_W-1:0]              rd_addr_c;

    // First stage: one pixel with its gathered neighbors
    logic                          s1_valid_reg;
    logic signed [PIXEL_BITS-1:0]  s1_px_reg;
    logic signed [PIXEL_BITS-1:0]  s1_up_reg;
    logic signed [PIXEL_BITS-1:0]  s1_bp_reg;
    logic signed [PIXEL_BITS-1:0]  s1_b_reg;
    logic signed [PIXEL_BITS-1:0]  s1_p1_reg;
    logic signed [PIXEL_BITS-1:0]  s1_p2_reg;
    logic [ROW_W-1:0]              s1_row_reg;
    logic [COL_W-1:0]              s1_col_reg;
    logic                          s1_has_main_reg;
    logic                          s1_has_left_reg;
    logic                          s1_has_cur_reg;
    logic                          s1_right_en_reg;

    logic signed [PIXEL_BITS-1:0]  right;
    logic signed [PIXEL_BITS-1:0]  up2;
    logic signed [PIXEL_BITS-1:0]  b3;
    logic signed [SUM_W-1:0]       sum_main;
    logic signed [SUM_W-1:0]       sum_left;
    logic signed [SUM_W-1:0]       sum_cur;
    logic [fnas_pkg::SLOT_W-1:0]   slot;

    assign accept      = in_valid && in_ready;
    assign cfg_restart = cfg_wr_en && ((cfg_index == fnas_pkg::CFG_FRAME_WIDTH) ||
                                       (cfg_index == fnas_pkg::CFG_FRAME_HEIGHT));
    assign last_col    = (col_reg == width_last_reg);
    assign last_row    = (row_reg == height_last_reg);

    // Entry view: {row r-2, row r-1} at the current column
    assign entry = fwd_valid_reg ? fwd_data_reg : mem_rd_data;
    assign older = entry[ENTRY_W-1 -: PIXEL_BITS];
    assign newer = entry[PIXEL_BITS-1:0];

    // Prefetch the next column's entry; wrap to column zero at row end
    assign rd_addr_c   = last_col ? '0 : col_reg + COL_W'(1);
    assign mem_wr_en   = accept;
    assign mem_wr_addr = col_reg;
    assign mem_wr_data = {newer, pixel_in};
    assign mem_rd_en   = accept;
    assign mem_rd_addr = rd_addr_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_last_reg  <= COL_W'(fnas_pkg::width_last(
                                   fnas_pkg::FRAME_WIDTH_W'(fnas_pkg::FRAME_WIDTH_RESET),
                                   fnas_pkg::WLAST_W'(MAX_COLS)));
            height_last_reg <= fnas_pkg::height_last(
                                   fnas_pkg::FRAME_HEIGHT_W'(fnas_pkg::FRAME_HEIGHT_RESET));
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                fnas_pkg::CFG_FRAME_WIDTH: begin
                    width_last_reg <= COL_W'(fnas_pkg::width_last(
                        cfg_wr_data[fnas_pkg::FRAME_WIDTH_W-1:0],
                        fnas_pkg::WLAST_W'(MAX_COLS)));
                end
                fnas_pkg::CFG_FRAME_HEIGHT: begin
                    height_last_reg <= fnas_pkg::height_last(
                        cfg_wr_data[fnas_pkg::FRAME_HEIGHT_W-1:0]);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        row_next   = row_reg;
        col_next   = col_reg;
        prev_next  = prev_reg;
        prev2_next = prev2_reg;
        bprev_next = bprev_reg;
        if (cfg_restart) begin
            row_next   = '0;
            col_next   = '0;
            prev_next  = '0;
            prev2_next = '0;
            bprev_next = '0;
        end else if (accept) begin
            if (last_col) begin
                col_next   = '0;
                row_next   = last_row ? '0 : row_reg + ROW_W'(1);
                prev_next  = '0;
                prev2_next = '0;
                bprev_next = '0;
            end else begin
                col_next   = col_reg + COL_W'(1);
                prev2_next = prev_reg;
                prev_next  = pixel_in;
                bprev_next = newer;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg       <= '0;
            col_reg       <= '0;
            prev_reg      <= '0;
            prev2_reg     <= '0;
            bprev_reg     <= '0;
            fwd_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
        end else begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            prev_reg     <= prev_next;
            prev2_reg    <= prev2_next;
            bprev_reg    <= bprev_next;
            s1_valid_reg <= accept;
            // Only a one-column frame reads back the entry it writes
            if (accept) begin
                fwd_valid_reg <= (rd_addr_c == col_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            fwd_data_reg    <= {newer, pixel_in};
            s1_px_reg       <= pixel_in;
            s1_up_reg       <= (row_reg[ROW_W-1:1] != '0) ? older : '0;
            s1_bp_reg       <= bprev_reg;
            s1_b_reg        <= newer;
            s1_p1_reg       <= prev_reg;
            s1_p2_reg       <= prev2_reg;
            s1_row_reg      <= row_reg;
            s1_col_reg      <= col_reg;
            s1_has_main_reg <= (row_reg != '0);
            s1_has_left_reg <= last_row && (col_reg != '0);
            s1_has_cur_reg  <= last_row && last_col;
            s1_right_en_reg <= !last_col;
        end
    end

    // The prefetched entry arrives now and supplies the right neighbor
    assign right = s1_right_en_reg ? newer : '0;
    assign up2   = (s1_row_reg != '0) ? s1_bp_reg : '0;
    assign b3    = (s1_row_reg != '0) ? s1_b_reg : '0;

    assign sum_main = SUM_W'(s1_up_reg) + SUM_W'(s1_bp_reg) + SUM_W'(right) + SUM_W'(s1_px_reg);
    assign sum_left = SUM_W'(up2) + SUM_W'(s1_p2_reg) + SUM_W'(s1_px_reg);
    assign sum_cur  = SUM_W'(b3) + SUM_W'(s1_p1_reg);

    // Pack results in emission order; the upper sum bits are the floor of sum / 4
    always_comb begin
        res_ctrl = '0;
        res_pix  = '0;
        slot     = '0;
        if (s1_has_main_reg) begin
            res_pix[slot]      = sum_main[SUM_W-1:2];
            res_ctrl.row[slot] = s1_row_reg - ROW_W'(1);
            res_ctrl.col[slot] = fnas_pkg::OUT_COL_W'(s1_col_reg);
            slot               = slot + fnas_pkg::SLOT_W'(1);
        end
        if (s1_has_left_reg) begin
            res_pix[slot]      = sum_left[SUM_W-1:2];
            res_ctrl.row[slot] = s1_row_reg;
            res_ctrl.col[slot] = fnas_pkg::OUT_COL_W'(s1_col_reg - COL_W'(1));
            slot               = slot + fnas_pkg::SLOT_W'(1);
        end
        if (s1_has_cur_reg) begin
            res_pix[slot]      = sum_cur[SUM_W-1:2];
            res_ctrl.row[slot] = s1_row_reg;
            res_ctrl.col[slot] = fnas_pkg::OUT_COL_W'(s1_col_reg);
            res_ctrl.eof[slot] = 1'b1;
            slot               = slot + fnas_pkg::SLOT_W'(1);
        end
        res_ctrl.count = slot;
    end

    assign res_valid  = s1_valid_reg && (slot != '0);
    assign stage_busy = s1_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fnas_result_queue.sv =====
// Result queue: holds per-pixel result groups and hands them out one result
// at a time, flagging the last of each group. Depends on fnas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fnas_result_queue #(
    parameter int PIXEL_BITS = fnas_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    push_valid,
    input  wire fnas_pkg::res_ctrl_t                     push_ctrl,
    input  wire logic [fnas_pkg::RESULTS_MAX-1:0][PIXEL_BITS-1:0] push_pix,
    input  wire logic                                    pending,
    output      logic                                    in_ready,
    output      logic                                    m_valid,
    input  wire logic                                    m_ready,
    output      logic signed [PIXEL_BITS-1:0]            pixel_out,
    output      logic [fnas_pkg::ROW_W-1:0]              out_row,
    output      logic [fnas_pkg::OUT_COL_W-1:0]          out_col,
    output      logic                                    last_of_run,
    output      logic                                    end_of_frame
);

    localparam int DEPTH = fnas_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fnas_pkg::res_ctrl_t                               ctrl_q [DEPTH];
    logic [fnas_pkg::RESULTS_MAX-1:0][PIXEL_BITS-1:0]  pix_q  [DEPTH];

    logic [PTR_W-1:0]            wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]            rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [fnas_pkg::SLOT_W-1:0] sel_reg, sel_next;
    logic [CNT_W:0]              occupancy;
    fnas_pkg::res_ctrl_t         head;
    logic                        take;
    logic                        pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Reserve room for the group still in the stage ahead
    assign occupancy = {1'b0, cnt_reg} + (CNT_W + 1)'(pending);
    assign in_ready  = (occupancy < (CNT_W + 1)'(DEPTH));

    assign head         = ctrl_q[rd_ptr_reg];
    assign m_valid      = (cnt_reg != '0);
    assign pixel_out    = pix_q[rd_ptr_reg][sel_reg];
    assign out_row      = head.row[sel_reg];
    assign out_col      = head.col[sel_reg];
    assign end_of_frame = head.eof[sel_reg];
    assign last_of_run  = (sel_reg == head.count - fnas_pkg::SLOT_W'(1));

    assign take = m_valid && m_ready;
    assign pop  = take && last_of_run;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        sel_next    = sel_reg;
        if (push_valid) begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
        end
        if (take) begin
            if (last_of_run) begin
                sel_next    = '0;
                rd_ptr_next = ptr_inc(rd_ptr_reg);
            end else begin
                sel_next = sel_reg + fnas_pkg::SLOT_W'(1);
            end
        end
        if (push_valid && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push_valid) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            sel_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            sel_reg    <= sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            ctrl_q[wr_ptr_reg] <= push_ctrl;
            pix_q[wr_ptr_reg]  <= push_pix;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/four_neighbor_average_stencil_core.sv =====
// Four-neighbor average stencil over a raster pixel stream.
// Each result passes the kernel's stage register and the result queue before it is offered.
// Throughput: one pixel per cycle unless the result queue is full; in the last row each
// pixel yields up to three results and the one-per-cycle result port sets the pace there.
// Reset clears counters and restores frame size 5120 x 8192; the line store is not
// cleared, since every entry is written before it is used.
`timescale 1ns / 1ps
`default_nettype none

module four_neighbor_average_stencil_core #(
    parameter int MAX_COLS   = fnas_pkg::DEF_MAX_COLS,
    parameter int PIXEL_BITS = fnas_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [fnas_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [fnas_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  wire logic                               s_valid,
    output      logic                               s_ready,
    input  wire logic signed [PIXEL_BITS-1:0]       s_pixel_in,
    output      logic                               m_valid,
    input  wire logic                               m_ready,
    output      logic signed [PIXEL_BITS-1:0]       m_pixel_out,
    output      logic [fnas_pkg::ROW_W-1:0]         m_out_row,
    output      logic [fnas_pkg::OUT_COL_W-1:0]     m_out_col,
    output      logic                               m_last_of_run,
    output      logic                               m_end_of_frame
);

    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ENTRY_W = 2 * PIXEL_BITS;

    logic                 mem_wr_en;
    logic [COL_W-1:0]     mem_wr_addr;
    logic [ENTRY_W-1:0]   mem_wr_data;
    logic                 mem_rd_en;
    logic [COL_W-1:0]     mem_rd_addr;
    logic [ENTRY_W-1:0]   mem_rd_data;
    logic                 stage_busy;
    logic                 res_valid;
    fnas_pkg::res_ctrl_t  res_ctrl;
    logic [fnas_pkg::RESULTS_MAX-1:0][PIXEL_BITS-1:0] res_pix;

    fnas_line_mem #(
        .DEPTH  (MAX_COLS),
        .WIDTH  (ENTRY_W),
        .ADDR_W (COL_W)
    ) u_line_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    fnas_kernel #(
        .MAX_COLS   (MAX_COLS),
        .PIXEL_BITS (PIXEL_BITS),
        .COL_W      (COL_W)
    ) u_kernel (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .pixel_in    (s_pixel_in),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .stage_busy  (stage_busy),
        .res_valid   (res_valid),
        .res_ctrl    (res_ctrl),
        .res_pix     (res_pix)
    );

    fnas_result_queue #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_result_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push_valid   (res_valid),
        .push_ctrl    (res_ctrl),
        .push_pix     (res_pix),
        .pending      (stage_busy),
        .in_ready     (s_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .pixel_out    (m_pixel_out),
        .out_row      (m_out_row),
        .out_col      (m_out_col),
        .last_of_run  (m_last_of_run),
        .end_of_frame (m_end_of_frame)
    );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for four_neighbor_average_stencil_core: random and directed frames,
// predicted averages checked in order. Depends on fnas_pkg and the core RTL.
`timescale 1ns / 1ps

typedef struct packed {
    logic [31:0] pixel;
    logic [15:0] row;
    logic [12:0] col;
    logic        last_of_run;
    logic        end_of_frame;
} stencil_result_t;

typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

class stencil_scoreboard;
    localparam int MAX_REPORTS = 30;

    bit [31:0]       newest_row [fnas_pkg::DEF_MAX_COLS];
    bit [31:0]       older_row  [fnas_pkg::DEF_MAX_COLS];
    bit [fnas_pkg::FRAME_WIDTH_W-1:0]  frame_width;
    bit [fnas_pkg::FRAME_HEIGHT_W-1:0] frame_height;
    int              row_count;
    int              col_count;
    bit [31:0]       left_pixel;
    bit [31:0]       left_left_pixel;
    stencil_result_t awaited_averages [$];
    int              errors;

    function new();
        frame_width  = fnas_pkg::FRAME_WIDTH_RESET;
        frame_height = fnas_pkg::FRAME_HEIGHT_RESET;
        errors       = 0;
        restart_frame();
    endfunction

    function void restart_frame();
        row_count       = 0;
        col_count       = 0;
        left_pixel      = '0;
        left_left_pixel = '0;
    endfunction

    function void write_register(logic [fnas_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] val);
        if (idx == fnas_pkg::CFG_FRAME_WIDTH) begin
            frame_width = val[fnas_pkg::FRAME_WIDTH_W-1:0];
            restart_frame();
        end else if (idx == fnas_pkg::CFG_FRAME_HEIGHT) begin
            frame_height = val;
            restart_frame();
        end
    endfunction

    // Floor of the sum over four: the arithmetic shift rounds toward minus infinity
    function logic [31:0] neighbor_average(logic [31:0] a, logic [31:0] b,
                                           logic [31:0] c, logic [31:0] d);
        logic signed [33:0] sum;
        logic signed [33:0] quarter;
        sum = {{2{a[31]}}, a} + {{2{b[31]}}, b} + {{2{c[31]}}, c} + {{2{d[31]}}, d};
        quarter = sum >>> 2;
        return quarter[31:0];
    endfunction

    function void add_average(logic [31:0] v, int r, int c, bit eof);
        stencil_result_t res;
        res.pixel        = v;
        res.row          = 16'(r);
        res.col          = 13'(c);
        res.last_of_run  = 1'b0;
        res.end_of_frame = eof;
        awaited_averages.push_back(res);
    endfunction

    function void note_pixel(logic [31:0] px);
        int              w;
        int              h;
        int              r;
        int              c;
        int              n;
        bit              last_row;
        bit              last_col;
        logic [31:0]     up;
        logic [31:0]     left;
        logic [31:0]     right;
        stencil_result_t tail;
        w = (frame_width == 0) ? 1 : frame_width;
        if (w > fnas_pkg::DEF_MAX_COLS) begin
            w = fnas_pkg::DEF_MAX_COLS;
        end
        h = (frame_height == 0) ? 1 : frame_height;
        if (col_count >= w || row_count >= h) begin
            restart_frame();
        end
        r = row_count;
        c = col_count;
        n = 0;
        last_row = (r + 1 >= h);
        last_col = (c + 1 >= w);

        // pixel above the current one closes the previous row's result
        up    = (r >= 2) ? older_row[c] : '0;
        left  = (c >= 1) ? older_row[c-1] : '0;
        right = !last_col ? newest_row[c+1] : '0;
        if (r >= 1) begin
            add_average(neighbor_average(up, left, right, px), r - 1, c, 1'b0);
            n++;
        end

        older_row[c]  = newest_row[c];
        newest_row[c] = px;

        if (last_row) begin
            if (c >= 1) begin
                up   = (r >= 1) ? older_row[c-1] : '0;
                left = (c >= 2) ? left_left_pixel : '0;
                add_average(neighbor_average(up, left, px, '0), r, c - 1, 1'b0);
                n++;
            end
            if (last_col) begin
                up   = (r >= 1) ? older_row[c] : '0;
                left = (c >= 1) ? left_pixel : '0;
                add_average(neighbor_average(up, left, '0, '0), r, c, 1'b1);
                n++;
            end
        end

        if (n > 0) begin
            tail = awaited_averages.pop_back();
            tail.last_of_run = 1'b1;
            awaited_averages.push_back(tail);
        end

        if (last_col) begin
            left_pixel      = '0;
            left_left_pixel = '0;
            col_count       = 0;
            row_count       = last_row ? 0 : r + 1;
        end else begin
            left_left_pixel = left_pixel;
            left_pixel      = px;
            col_count       = c + 1;
        end
    endfunction

    task report(string what);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("mismatch: %s", what);
        end
    endtask

    task check_result(logic [31:0] px, logic [15:0] row, logic [12:0] col,
                      logic last_of_run, logic end_of_frame);
        stencil_result_t want;
        if (awaited_averages.size() == 0) begin
            report($sformatf("unexpected result row %0d col %0d", row, col));
            return;
        end
        want = awaited_averages.pop_front();
        if (px !== want.pixel) begin
            report($sformatf("pixel_out at (%0d,%0d): got %h, want %h",
                             want.row, want.col, px, want.pixel));
        end
        if (row !== want.row) begin
            report($sformatf("out_row: got %0d, want %0d", row, want.row));
        end
        if (col !== want.col) begin
            report($sformatf("out_col at row %0d: got %0d, want %0d", want.row, col, want.col));
        end
        if (last_of_run !== want.last_of_run) begin
            report($sformatf("last_of_run at (%0d,%0d): got %b, want %b",
                             want.row, want.col, last_of_run, want.last_of_run));
        end
        if (end_of_frame !== want.end_of_frame) begin
            report($sformatf("end_of_frame at (%0d,%0d): got %b, want %b",
                             want.row, want.col, end_of_frame, want.end_of_frame));
        end
    endtask

    function int awaited_count();
        return awaited_averages.size();
    endfunction
endclass

module testbench;
    import fnas_pkg::*;

    localparam int          RANDOM_ITEMS   = 290;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [31:0] PIX_MIN        = 32'h8000_0000;
    localparam logic [31:0] PIX_MAX        = 32'h7FFF_FFFF;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_wr_data;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [31:0]       s_pixel_in;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [31:0]       m_pixel_out;
    logic [ROW_W-1:0]         m_out_row;
    logic [OUT_COL_W-1:0]     m_out_col;
    logic                     m_last_of_run;
    logic                     m_end_of_frame;

    stencil_scoreboard sb;
    int                src_idle_pct   = 0;
    int                sink_stall_pct = 0;
    bit                hold_req       = 1'b0;
    int                quiet_cycles   = 0;

    four_neighbor_average_stencil_core DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel_in     (s_pixel_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_out    (m_pixel_out),
        .m_out_row      (m_out_row),
        .m_out_col      (m_out_col),
        .m_last_of_run  (m_last_of_run),
        .m_end_of_frame (m_end_of_frame)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: check what was taken at this edge, then pick next ready
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                sb.check_result(m_pixel_out, m_out_row, m_out_col, m_last_of_run,
                                m_end_of_frame);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (!aresetn || hold_left > 0) begin
                m_ready <= 1'b0;
                if (hold_left > 0) begin
                    hold_left--;
                end
            end else begin
                m_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    function automatic logic [31:0] random_pixel();
        case ($urandom_range(7))
            0: return PIX_MIN;
            1: return PIX_MAX;
            2: return '1;
            3: return '0;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_pixel(input logic [31:0] px);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_pixel_in <= px;
        @(posedge aclk);
        while (s_ready !== 1'b1) begin
            @(posedge aclk);
        end
        sb.note_pixel(px);
    endtask

    // Drop valid, drain every awaited result, then let the pipeline settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.awaited_count() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        sb.write_register(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [15:0] width, input logic [15:0] height);
        wait_idle();
        write_register(CFG_FRAME_WIDTH, width);
        write_register(CFG_FRAME_HEIGHT, height);
    endtask

    task automatic run_phase(input int width, input int height, input int count,
                             input idle_mode_e mode, input bit hold_sink);
        case (mode)
            IDLE_NONE:     begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            IDLE_SENDER:   begin src_idle_pct = 50; sink_stall_pct = 0;  end
            IDLE_RECEIVER: begin src_idle_pct = 0;  sink_stall_pct = 50; end
            default:       begin src_idle_pct = 23; sink_stall_pct = 23; end
        endcase
        configure(16'(width), 16'(height));
        if (hold_sink) begin
            hold_req = 1'b1;
        end
        repeat (count) send_pixel(random_pixel());
    endtask

    initial begin
        int random_items;
        int phase;
        int pick;
        int w;
        int h;
        int eff_w;
        int eff_h;
        int n;
        sb = new();
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= CFG_FRAME_WIDTH;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_pixel_in  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset frame size: first row only, then cut short by a register write
        send_pixel(PIX_MIN);
        send_pixel(PIX_MAX);

        // 3x3 frames at the pixel extremes; a spare index write must not restart
        configure(16'd3, 16'd3);
        repeat (9) send_pixel(PIX_MIN);
        repeat (5) send_pixel(PIX_MAX);
        wait_idle();
        write_register(CFG_SPARE, 16'hFFFF);
        repeat (4) send_pixel(PIX_MAX);

        // zero sizes act as one: every pixel is a whole frame
        configure(16'd0, 16'd0);
        send_pixel(32'd1);
        send_pixel(32'hFFFF_FFFF);

        // single-row frame, then wrap into the next frame
        configure(16'd2, 16'd1);
        send_pixel(32'h5555_5555);
        send_pixel(32'hAAAA_AAAA);
        send_pixel(32'd0);

        // size extremes: oversized width register, tallest frame
        run_phase(16'hFFFF, 1, 40, IDLE_BOTH, 1'b0);
        run_phase(2, 65535, 40, IDLE_RECEIVER, 1'b0);

        // long receiver hold while pixels keep coming
        run_phase(4, 6, 60, IDLE_NONE, 1'b1);

        random_items = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(15);
            if (pick == 0) begin
                w = 0;
            end else if (pick == 1) begin
                w = $urandom_range(9, 40);
            end else begin
                w = $urandom_range(1, 8);
            end
            h     = $urandom_range(0, 6);
            eff_w = (w == 0) ? 1 : w;
            eff_h = (h == 0) ? 1 : h;
            // mostly whole frames, with a partial one trailing
            n = eff_w * eff_h * $urandom_range(1, 2) + $urandom_range(0, eff_w);
            if (n > 150) begin
                n = 150;
            end
            if (n > RANDOM_ITEMS - random_items) begin
                n = RANDOM_ITEMS - random_items;
            end
            run_phase(w, h, n, idle_mode_e'(phase % 4), 1'b0);
            random_items += n;
            phase++;
        end

        wait_idle();
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
